// ===== rtl/qsbed_pkg.sv =====
// shared types and character constants of the quoted string escape decoder
`default_nettype none
package qsbed_pkg;

	// characters that steer the decoding
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_X_UP   = 8'h58;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A_LO   = 8'h61;
	localparam logic [7:0] CH_F_LO   = 8'h66;
	localparam logic [7:0] CH_A_UP   = 8'h41;
	localparam logic [7:0] CH_F_UP   = 8'h46;

	// decimal escape limits
	localparam logic [9:0] DEC_BASE      = 10'd10;
	localparam logic [9:0] MAX_DEC_VALUE = 10'd255;
	localparam int         MAX_DIGITS    = 3;

	// held bytes between transactions, and the working window of one step
	localparam int HOLD_DEPTH = 4;
	localparam int WORK_DEPTH = 5;

	// byte class worked out once on entry
	typedef struct packed {
		logic       dig;
		logic       hex;
		logic [3:0] nib;
		logic       bs;
		logic       dq;
		logic       sq;
		logic       x;
	} cls_t;

	typedef struct packed {
		logic [7:0] data;
		cls_t       cls;
	} sym_t;

	typedef struct packed {
		sym_t sym;
		logic last;
	} item_t;

endpackage
`default_nettype wire

// ===== rtl/quoted_string_byte_escape_decoder_unit.sv =====
// path: a byte decided on arrival passes the queue, the pending result and the output register before m_tvalid
// throughput: one input byte per cycle while the queue is not full; the sequencer emits one result byte
//   per cycle unless the output stalls, and takes no new byte from the queue while a step bursting
//   several results is still running
// reset: arst_n clears the queue, string and escape state and the output valid;
//   held escape bytes are not cleared
`default_nettype none
module quoted_string_byte_escape_decoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // in_byte
	input  logic       s_tlast,  // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // out_byte
	output logic       m_tuser,  // run_last
	output logic       m_tlast   // text_end
);
	import qsbed_pkg::*;

	item_t in_item;
	item_t q_item;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_valid;

	// classify and accept
	qsbed_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (in_item)
	);

	// decoupling queue
	qsbed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (in_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (q_item)
	);

	// decode and deliver
	qsbed_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/qsbed_front.sv =====
// input side: takes byte transactions and classifies each byte for the queue
`default_nettype none
module qsbed_front (
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // in_byte
	input  logic             s_tlast,  // in_last
	input  logic             q_full,
	output logic             q_push,
	output qsbed_pkg::item_t q_item
);
	import qsbed_pkg::*;

	logic is_dig;
	logic is_hlo;
	logic is_hup;

	// handshake towards the queue
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// character classes
	assign is_dig = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
	assign is_hlo = (s_tdata >= CH_A_LO) && (s_tdata <= CH_F_LO);
	assign is_hup = (s_tdata >= CH_A_UP) && (s_tdata <= CH_F_UP);

	always_comb begin
		q_item.sym.data    = s_tdata;
		q_item.sym.cls.dig = is_dig;
		q_item.sym.cls.hex = is_dig || is_hlo || is_hup;
		// letters a-f and A-F share the low nibble pattern 1..6
		q_item.sym.cls.nib = is_dig ? s_tdata[3:0] : s_tdata[3:0] + 4'd9;
		q_item.sym.cls.bs  = (s_tdata == CH_BSLASH);
		q_item.sym.cls.dq  = (s_tdata == CH_DQUOTE);
		q_item.sym.cls.sq  = (s_tdata == CH_SQUOTE);
		q_item.sym.cls.x   = (s_tdata == CH_X_LO) || (s_tdata == CH_X_UP);
		q_item.last        = s_tlast;
	end

endmodule
`default_nettype wire

// ===== rtl/qsbed_queue.sv =====
// small queue of classified bytes between the front and the back
`default_nettype none
module qsbed_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qsbed_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output qsbed_pkg::item_t pop_item
);
	import qsbed_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign valid    = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_item = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/qsbed_back.sv =====
// back side: escape sequencer, run-end resolution and output register
`default_nettype none
module qsbed_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  qsbed_pkg::item_t q_item,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,  // out_byte
	output logic             m_tuser,  // run_last
	output logic             m_tlast   // text_end
);
	import qsbed_pkg::*;

	typedef struct packed {
		logic       more;
		logic       ok;
		logic [7:0] val;
		logic [2:0] stop;
	} dec_t;

	// read up to three decimal digits starting at position at
	function automatic dec_t rd_dec(input sym_t [WORK_DEPTH-1:0] b, input logic [2:0] n,
			input logic [2:0] at, input logic fin);
		dec_t       r;
		logic [9:0] v;
		logic       stp;
		logic [2:0] pos;
		r   = '0;
		v   = '0;
		stp = 1'b0;
		pos = at;
		if (at >= n) begin
			r.more = !fin;
		end else if (b[at].cls.dig) begin
			r.stop = at;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				pos = at + 3'(i);
				if (!stp && !r.more) begin
					if (pos >= n) begin
						if (fin) begin
							stp = 1'b1;
						end else begin
							r.more = 1'b1;
						end
					end else if (!b[pos].cls.dig) begin
						stp = 1'b1;
					end else begin
						v      = v * DEC_BASE + 10'(b[pos].cls.nib);
						r.stop = pos + 3'd1;
					end
				end
			end
			if (!r.more && (v <= MAX_DEC_VALUE)) begin
				r.ok  = 1'b1;
				r.val = v[7:0];
			end
		end
		return r;
	endfunction

	// sequencer state
	logic                    active_q;
	logic [2:0]              n_q;
	sym_t [HOLD_DEPTH-1:0]   buf_q;
	logic                    end_q;
	logic                    lit_q;
	logic                    ins_q;
	logic                    qs_q;

	// one result waiting until its run end is known
	logic                    pend_v_q;
	logic                    pend_known_q;
	logic                    pend_end_q;
	logic [7:0]              pend_byte_q;

	// output register
	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic                    out_run_q;
	logic                    out_end_q;

	sym_t [WORK_DEPTH-1:0]   w;
	sym_t [HOLD_DEPTH-1:0]   shifted;
	logic [2:0]              wn;
	logic                    wend;
	logic                    wlit;
	logic                    space;
	logic                    en;
	logic                    go;
	logic                    emit;
	logic                    und;
	logic                    fb;
	logic [7:0]              ev;
	logic [2:0]              k;
	logic [2:0]              rem;
	logic                    lit_n;
	logic                    ins_n;
	logic                    qs_n;
	logic                    qmatch;
	logic                    done;
	logic                    push;
	logic                    push_last;
	dec_t                    rd1;
	dec_t                    rd2;

	// flow control
	assign space = !out_valid_q || m_tready;
	assign en    = !pend_v_q || space;
	assign go    = en && (active_q || q_valid);
	assign q_pop = go && !active_q;

	// working window: held bytes plus the new byte, or the rest of a running step
	always_comb begin
		for (int i = 0; i < WORK_DEPTH; i++) begin
			w[i] = '0;
			if (active_q) begin
				if (i < HOLD_DEPTH) begin
					w[i] = buf_q[i];
				end
			end else if (i < HOLD_DEPTH && 3'(i) < n_q) begin
				w[i] = buf_q[i];
			end else if (3'(i) == n_q) begin
				w[i] = q_item.sym;
			end
		end
		wn   = active_q ? n_q : n_q + 3'd1;
		wend = active_q ? end_q : q_item.last;
		wlit = active_q && lit_q;
	end

	assign rd1    = rd_dec(w, wn, 3'd1, wend);
	assign rd2    = rd_dec(w, wn, 3'd2, wend);
	assign qmatch = qs_q ? w[0].cls.sq : w[0].cls.dq;

	// decide the leading bytes of the window
	always_comb begin
		emit  = 1'b0;
		und   = 1'b0;
		fb    = 1'b0;
		ev    = w[0].data;
		k     = 3'd1;
		lit_n = 1'b0;
		ins_n = ins_q;
		qs_n  = qs_q;
		if (wn == 3'd0) begin
			und = 1'b1;
		end else if (wlit) begin
			emit = 1'b1;
		end else if (!ins_q) begin
			emit = 1'b1;
			if (w[0].cls.dq || w[0].cls.sq) begin
				ins_n = 1'b1;
				qs_n  = w[0].cls.sq;
			end
		end else if (qmatch) begin
			emit  = 1'b1;
			ins_n = 1'b0;
			qs_n  = 1'b0;
		end else if (!w[0].cls.bs || (wn == 3'd1 && wend)) begin
			emit = 1'b1;
		end else if (wn == 3'd1) begin
			und = 1'b1;
		end else begin
			fb = 1'b1;
			// doubled backslash then decimal digits
			if (w[1].cls.bs) begin
				if (rd2.more) begin
					und = 1'b1;
					fb  = 1'b0;
				end else if (rd2.ok) begin
					emit = 1'b1;
					ev   = rd2.val;
					k    = rd2.stop;
					fb   = 1'b0;
				end
			end
			// backslash x and two hex digits
			if (fb && w[1].cls.x) begin
				if (wn >= 3'd4) begin
					if (w[2].cls.hex && w[3].cls.hex) begin
						emit = 1'b1;
						ev   = {w[2].cls.nib, w[3].cls.nib};
						k    = 3'd4;
						fb   = 1'b0;
					end
				end else if (!wend) begin
					und = 1'b1;
					fb  = 1'b0;
				end
			end
			// backslash then decimal digits
			if (fb && w[1].cls.dig) begin
				if (rd1.more) begin
					und = 1'b1;
					fb  = 1'b0;
				end else if (rd1.ok) begin
					emit = 1'b1;
					ev   = rd1.val;
					k    = rd1.stop;
					fb   = 1'b0;
				end
			end
			// fallback: backslash now, the next byte literally in the following step
			if (fb) begin
				emit  = 1'b1;
				lit_n = 1'b1;
			end
		end
	end

	assign rem  = wn - k;
	assign done = und || (rem == 3'd0);

	// window after consuming k bytes
	always_comb begin
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			shifted[i] = '0;
			for (int j = 0; j < WORK_DEPTH; j++) begin
				if (4'(j) == 4'(i) + 4'(k)) begin
					shifted[i] = w[j];
				end
			end
		end
	end

	// pending result leaves when its run end is settled
	assign push      = pend_v_q && space && (pend_known_q || go);
	assign push_last = pend_known_q || und;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			n_q      <= '0;
			end_q    <= 1'b0;
			lit_q    <= 1'b0;
			ins_q    <= 1'b0;
			qs_q     <= 1'b0;
		end else if (go) begin
			end_q <= wend;
			if (done) begin
				active_q <= 1'b0;
				lit_q    <= 1'b0;
				if (wend) begin
					n_q   <= '0;
					ins_q <= 1'b0;
					qs_q  <= 1'b0;
				end else begin
					n_q   <= und ? wn : 3'd0;
					ins_q <= ins_n;
					qs_q  <= qs_n;
				end
			end else begin
				active_q <= 1'b1;
				n_q      <= rem;
				lit_q    <= lit_n;
				ins_q    <= ins_n;
				qs_q     <= qs_n;
			end
		end
	end

	// window bytes
	always_ff @(posedge clk) begin
		if (go) begin
			buf_q <= und ? w[HOLD_DEPTH-1:0] : shifted;
		end
	end

	// pending result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q     <= 1'b0;
			pend_known_q <= 1'b0;
			pend_end_q   <= 1'b0;
		end else if (go && emit) begin
			pend_v_q     <= 1'b1;
			pend_known_q <= (rem == 3'd0);
			pend_end_q   <= wend && (rem == 3'd0);
		end else if (push) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			pend_byte_q <= ev;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_byte_q <= pend_byte_q;
			out_run_q  <= push_last;
			out_end_q  <= pend_known_q && pend_end_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_run_q;
	assign m_tlast  = out_end_q;

endmodule
`default_nettype wire

// ===== rtl/qsbed_checker.sv =====
// port checks for the escape decoder and their binding to the top level
`default_nettype none
module qsbed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// nothing is offered while reset is held
	assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	// the end of a text always closes the run of its input byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("text end without run end");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// with no input and no result offered, the input is ready afterwards unless a result is offered by then
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tvalid && !m_tvalid |=> s_tready || m_tvalid || $past(m_tvalid))
		else $error("input stalled with no pending results");

endmodule

bind quoted_string_byte_escape_decoder_unit qsbed_checker u_chk (.*);
`default_nettype wire
